// ===== rtl/core/ose_pkg.sv =====
// Shared types and codes for the operand stack engine.
`timescale 1ns / 1ps
`default_nettype none
package ose_pkg;

	// Command codes carried in the input tuser field.
	localparam logic [3:0] CMD_PUSH  = 4'd0;
	localparam logic [3:0] CMD_POP   = 4'd1;
	localparam logic [3:0] CMD_POPB  = 4'd2;
	localparam logic [3:0] CMD_REV   = 4'd3;
	localparam logic [3:0] CMD_SWAP  = 4'd4;
	localparam logic [3:0] CMD_DUP   = 4'd5;
	localparam logic [3:0] CMD_MOVE  = 4'd6;
	localparam logic [3:0] CMD_ROT   = 4'd7;
	localparam logic [3:0] CMD_CLEAR = 4'd8;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Read address selects.
	localparam logic [2:0] RA_TOP  = 3'd0;
	localparam logic [2:0] RA_ZERO = 3'd1;
	localparam logic [2:0] RA_I    = 3'd2;
	localparam logic [2:0] RA_K    = 3'd3;
	localparam logic [2:0] RA_K1   = 3'd4;
	localparam logic [2:0] RA_IDX  = 3'd5;

	// Write address selects.
	localparam logic [1:0] WA_CNT = 2'd0;
	localparam logic [1:0] WA_I   = 2'd1;
	localparam logic [1:0] WA_K   = 2'd2;
	localparam logic [1:0] WA_TOP = 2'd3;

	// Write data selects.
	localparam logic [1:0] WD_PUSH = 2'd0;
	localparam logic [1:0] WD_RD   = 2'd1;
	localparam logic [1:0] WD_TMP  = 2'd2;

	// Entry count updates.
	localparam logic [1:0] CN_HOLD = 2'd0;
	localparam logic [1:0] CN_INC  = 2'd1;
	localparam logic [1:0] CN_DEC  = 2'd2;
	localparam logic [1:0] CN_CLR  = 2'd3;

	// Walk pointer updates.
	localparam logic [2:0] PT_HOLD = 3'd0;
	localparam logic [2:0] PT_REV  = 3'd1;
	localparam logic [2:0] PT_SWAP = 3'd2;
	localparam logic [2:0] PT_STEP = 3'd3;
	localparam logic [2:0] PT_IDX  = 3'd4;
	localparam logic [2:0] PT_ZERO = 3'd5;
	localparam logic [2:0] PT_KINC = 3'd6;

	// Repeat counter updates.
	localparam logic [1:0] RP_HOLD = 2'd0;
	localparam logic [1:0] RP_ONE  = 2'd1;
	localparam logic [1:0] RP_LOAD = 2'd2;
	localparam logic [1:0] RP_DEC  = 2'd3;

	// Width of the input tdata bus.
	localparam int IN_DATA_W = 48;

	typedef struct packed {
		logic       in_ld;
		logic       rd_en;
		logic [2:0] rd_sel;
		logic       wr_en;
		logic [1:0] wr_sel;
		logic [1:0] wd_sel;
		logic       tmp_ld;
		logic [1:0] cnt_op;
		logic [2:0] ptr_op;
		logic [1:0] rep_op;
		logic       res_clr;
		logic       res_ld;
		logic       st_ld;
		logic [1:0] st_code;
		logic       out_ld;
	} dp_cmd_t;

	typedef struct packed {
		logic [3:0] cmd;
		logic       empty;
		logic       full;
		logic       two_plus;
		logic       single;
		logic       mv_ok;
		logic       rep_zero;
		logic       rep_gt1;
		logic       rev_more;
		logic       sh_more;
	} dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/operand_stack_engine_unit.sv =====
// Top level of the operand stack engine: stream ports, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none
// The operand stack engine keeps up to STACK_DEPTH tagged entries (a 32-bit value and a
// number/handle tag) in a single-port-write, single-port-read memory and runs one command per
// input transaction, returning exactly one result transaction with the removed entry (pop and
// pop bottom), the depth after the command and a status (ok, too few entries, stack full).
// Failing commands leave the stack unchanged. Every memory access goes through the one read and
// one write port, so the cost of a command is set by how many entries it touches: reverse swaps
// floor(depth / 2) pairs, pop bottom shifts the other depth - 1 entries down, and move to top of
// position n shifts the n - 1 entries above it down per repetition (rotate repeats it the
// requested number of times). A finished result sits in an output register, and the next
// transaction is taken in the same cycle the result is loaded there.
module operand_stack_engine_unit #(
	parameter int STACK_DEPTH = 64
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	// [31:0] push_value, [38:32] position, [44:39] repeat_req, [47:45] zero
	input  wire [ose_pkg::IN_DATA_W-1:0] s_tdata,
	// [3:0] cmd, [4] push_is_number
	input  wire [4:0]  s_tuser,
	output logic       m_tvalid,
	input  wire        m_tready,
	// [31:0] out_value, then depth_now, then status (2 bits), zero padded to whole bytes
	output logic [((34 + $clog2(STACK_DEPTH+1) + 7) / 8) * 8 - 1:0] m_tdata,
	// [0] out_is_number
	output logic       m_tuser
);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int OW = ((34 + CW + 7) / 8) * 8;

	ose_pkg::dp_cmd_t ctl;
	ose_pkg::dp_sts_t sts;
	logic [31:0]   o_value;
	logic [CW-1:0] o_depth;
	logic [1:0]    o_status;

	ose_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	ose_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.in_cmd        (s_tuser[3:0]),
		.in_value      (s_tdata[31:0]),
		.in_is_number  (s_tuser[4]),
		.in_position   (s_tdata[38:32]),
		.in_repeat     (s_tdata[44:39]),
		.sts           (sts),
		.out_value     (o_value),
		.out_is_number (m_tuser),
		.depth_now     (o_depth),
		.status        (o_status)
	);

	// Result fields packed from the lowest bit up.
	assign m_tdata = OW'({o_status, o_depth, o_value});

	// The reported depth never exceeds the capacity.
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (o_depth <= CW'(STACK_DEPTH)))
		else $error("reported depth beyond capacity");

	// A full-stack failure is reported only when the stack is at capacity.
	a_full_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (o_status == ose_pkg::ST_FULL)) |-> (o_depth == CW'(STACK_DEPTH)))
		else $error("full status with room left");

	// A too-few-entries failure leaves fewer than two entries on the stack.
	a_under_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (o_status == ose_pkg::ST_UNDER)) |-> (o_depth < CW'(2)))
		else $error("underflow status with entries present");

endmodule
`default_nettype wire

// ===== rtl/core/ose_dp.sv =====
// Datapath of the operand stack engine: entry memory, pointers, count and result registers.
`timescale 1ns / 1ps
`default_nettype none
module ose_dp #(
	parameter int STACK_DEPTH = 64
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  ose_pkg::dp_cmd_t     ctl,
	input  wire [3:0]            in_cmd,
	input  wire [31:0]           in_value,
	input  wire                  in_is_number,
	input  wire [6:0]            in_position,
	input  wire [5:0]            in_repeat,
	output ose_pkg::dp_sts_t     sts,
	output logic [31:0]          out_value,
	output logic                 out_is_number,
	output logic [$clog2(STACK_DEPTH+1)-1:0] depth_now,
	output logic [1:0]           status
);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int PW = (CW > 7) ? CW : 7;
	localparam int KW = CW + 1;

	logic [32:0]   mem_q [STACK_DEPTH];
	logic [32:0]   rd_q;
	logic [32:0]   tmp_q;
	logic [3:0]    cmd_q;
	logic [31:0]   pval_q;
	logic          ptag_q;
	logic [6:0]    pos_q;
	logic [5:0]    rep_in_q;
	logic [5:0]    rep_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] i_q, k_q;
	logic [31:0]   res_val_q;
	logic          res_tag_q;
	logic [1:0]    res_st_q;

	logic [CW-1:0] cnt_m1, cnt_m2;
	logic [AW-1:0] top_a, idx_a, k1_a, rd_a, wr_a;
	logic [PW-1:0] cnt_w, pos_w, idx_w;
	logic [32:0]   wd;

	assign cnt_m1 = cnt_q - CW'(1);
	assign cnt_m2 = cnt_q - CW'(2);
	assign top_a  = cnt_m1[AW-1:0];
	assign cnt_w  = PW'(cnt_q);
	assign pos_w  = PW'(pos_q);
	assign idx_w  = cnt_w - pos_w;
	assign idx_a  = idx_w[AW-1:0];
	assign k1_a   = k_q + AW'(1);

	always_comb begin
		case (ctl.rd_sel)
			ose_pkg::RA_TOP:  rd_a = top_a;
			ose_pkg::RA_ZERO: rd_a = '0;
			ose_pkg::RA_I:    rd_a = i_q;
			ose_pkg::RA_K:    rd_a = k_q;
			ose_pkg::RA_K1:   rd_a = k1_a;
			ose_pkg::RA_IDX:  rd_a = idx_a;
			default:          rd_a = top_a;
		endcase
		case (ctl.wr_sel)
			ose_pkg::WA_CNT: wr_a = cnt_q[AW-1:0];
			ose_pkg::WA_I:   wr_a = i_q;
			ose_pkg::WA_K:   wr_a = k_q;
			ose_pkg::WA_TOP: wr_a = top_a;
			default:         wr_a = top_a;
		endcase
		case (ctl.wd_sel)
			ose_pkg::WD_PUSH: wd = {ptag_q, pval_q};
			ose_pkg::WD_RD:   wd = rd_q;
			ose_pkg::WD_TMP:  wd = tmp_q;
			default:          wd = rd_q;
		endcase
	end

	// Entry memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_a] <= wd;
		end
		if (ctl.rd_en) begin
			rd_q <= mem_q[rd_a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (ctl.cnt_op)
				ose_pkg::CN_INC: cnt_q <= cnt_q + CW'(1);
				ose_pkg::CN_DEC: cnt_q <= cnt_m1;
				ose_pkg::CN_CLR: cnt_q <= '0;
				default:         cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.in_ld) begin
			cmd_q    <= in_cmd;
			pval_q   <= in_value;
			ptag_q   <= in_is_number;
			pos_q    <= in_position;
			rep_in_q <= in_repeat;
		end
		if (ctl.tmp_ld) begin
			tmp_q <= rd_q;
		end
		case (ctl.ptr_op)
			ose_pkg::PT_REV: begin
				i_q <= '0;
				k_q <= top_a;
			end
			ose_pkg::PT_SWAP: begin
				i_q <= top_a;
				k_q <= cnt_m2[AW-1:0];
			end
			ose_pkg::PT_STEP: begin
				i_q <= i_q + AW'(1);
				k_q <= k_q - AW'(1);
			end
			ose_pkg::PT_IDX:  k_q <= idx_a;
			ose_pkg::PT_ZERO: k_q <= '0;
			ose_pkg::PT_KINC: k_q <= k1_a;
			default: begin
				i_q <= i_q;
				k_q <= k_q;
			end
		endcase
		case (ctl.rep_op)
			ose_pkg::RP_ONE:  rep_q <= 6'd1;
			ose_pkg::RP_LOAD: rep_q <= rep_in_q;
			ose_pkg::RP_DEC:  rep_q <= rep_q - 6'd1;
			default:          rep_q <= rep_q;
		endcase
		if (ctl.res_clr) begin
			res_val_q <= '0;
			res_tag_q <= 1'b0;
		end else if (ctl.res_ld) begin
			res_val_q <= rd_q[31:0];
			res_tag_q <= rd_q[32];
		end
		if (ctl.st_ld) begin
			res_st_q <= ctl.st_code;
		end
		if (ctl.out_ld) begin
			out_value     <= res_val_q;
			out_is_number <= res_tag_q;
			depth_now     <= cnt_q;
			status        <= res_st_q;
		end
	end

	always_comb begin
		sts.cmd      = cmd_q;
		sts.empty    = (cnt_q == '0);
		sts.full     = (cnt_q == CW'(STACK_DEPTH));
		sts.two_plus = (cnt_q >= CW'(2));
		sts.single   = (cnt_q == CW'(1));
		sts.mv_ok    = (pos_w >= PW'(2)) && (pos_w <= cnt_w);
		sts.rep_zero = (rep_in_q == '0);
		sts.rep_gt1  = (rep_q > 6'd1);
		sts.rev_more = (KW'(i_q) + KW'(2)) < KW'(k_q);
		sts.sh_more  = (KW'(k_q) + KW'(2)) < KW'(cnt_q);
	end

endmodule
`default_nettype wire

// ===== rtl/core/ose_ctrl.sv =====
// Controller state machine of the operand stack engine.
`timescale 1ns / 1ps
`default_nettype none
module ose_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  wire              m_tready,
	input  ose_pkg::dp_sts_t sts,
	output ose_pkg::dp_cmd_t ctl
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DEC   = 4'd1;
	localparam logic [3:0] S_POPW  = 4'd2;
	localparam logic [3:0] S_DUPW  = 4'd3;
	localparam logic [3:0] S_PBW   = 4'd4;
	localparam logic [3:0] S_PRA   = 4'd5;
	localparam logic [3:0] S_PRB   = 4'd6;
	localparam logic [3:0] S_PWA   = 4'd7;
	localparam logic [3:0] S_PWB   = 4'd8;
	localparam logic [3:0] S_MVRD  = 4'd9;
	localparam logic [3:0] S_MVT   = 4'd10;
	localparam logic [3:0] S_SHR   = 4'd11;
	localparam logic [3:0] S_SHW   = 4'd12;
	localparam logic [3:0] S_MVEND = 4'd13;
	localparam logic [3:0] S_FIN   = 4'd14;

	logic [3:0] state_q, state_d;
	logic       ov_q;
	logic       slot_free;

	assign slot_free = !ov_q || m_tready;
	assign s_tready  = (state_q == S_IDLE) || ((state_q == S_FIN) && slot_free);
	assign m_tvalid  = ov_q;

	always_comb begin
		ctl         = '0;
		ctl.in_ld   = s_tvalid && s_tready;
		ctl.out_ld  = (state_q == S_FIN) && slot_free;
		ctl.st_code = ose_pkg::ST_OK;
		state_d     = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				ctl.res_clr = 1'b1;
				ctl.st_ld   = 1'b1;
				state_d     = S_FIN;
				case (sts.cmd)
					ose_pkg::CMD_PUSH: begin
						if (sts.full) begin
							ctl.st_code = ose_pkg::ST_FULL;
						end else begin
							ctl.wr_en  = 1'b1;
							ctl.wr_sel = ose_pkg::WA_CNT;
							ctl.wd_sel = ose_pkg::WD_PUSH;
							ctl.cnt_op = ose_pkg::CN_INC;
						end
					end
					ose_pkg::CMD_POP: begin
						if (sts.empty) begin
							ctl.st_code = ose_pkg::ST_UNDER;
						end else begin
							ctl.rd_en  = 1'b1;
							ctl.rd_sel = ose_pkg::RA_TOP;
							state_d    = S_POPW;
						end
					end
					ose_pkg::CMD_POPB: begin
						if (sts.empty) begin
							ctl.st_code = ose_pkg::ST_UNDER;
						end else begin
							ctl.rd_en  = 1'b1;
							ctl.rd_sel = ose_pkg::RA_ZERO;
							state_d    = S_PBW;
						end
					end
					ose_pkg::CMD_REV: begin
						if (sts.two_plus) begin
							ctl.ptr_op = ose_pkg::PT_REV;
							state_d    = S_PRA;
						end
					end
					ose_pkg::CMD_SWAP: begin
						if (!sts.two_plus) begin
							ctl.st_code = ose_pkg::ST_UNDER;
						end else begin
							ctl.ptr_op = ose_pkg::PT_SWAP;
							state_d    = S_PRA;
						end
					end
					ose_pkg::CMD_DUP: begin
						if (sts.empty) begin
							ctl.st_code = ose_pkg::ST_UNDER;
						end else if (sts.full) begin
							ctl.st_code = ose_pkg::ST_FULL;
						end else begin
							ctl.rd_en  = 1'b1;
							ctl.rd_sel = ose_pkg::RA_TOP;
							state_d    = S_DUPW;
						end
					end
					ose_pkg::CMD_MOVE: begin
						if (sts.mv_ok) begin
							ctl.rep_op = ose_pkg::RP_ONE;
							state_d    = S_MVRD;
						end
					end
					ose_pkg::CMD_ROT: begin
						if (sts.mv_ok && !sts.rep_zero) begin
							ctl.rep_op = ose_pkg::RP_LOAD;
							state_d    = S_MVRD;
						end
					end
					ose_pkg::CMD_CLEAR: begin
						ctl.cnt_op = ose_pkg::CN_CLR;
					end
					default: begin
						state_d = S_FIN;
					end
				endcase
			end
			S_POPW: begin
				ctl.res_ld = 1'b1;
				ctl.cnt_op = ose_pkg::CN_DEC;
				state_d    = S_FIN;
			end
			S_DUPW: begin
				ctl.wr_en  = 1'b1;
				ctl.wr_sel = ose_pkg::WA_CNT;
				ctl.wd_sel = ose_pkg::WD_RD;
				ctl.cnt_op = ose_pkg::CN_INC;
				state_d    = S_FIN;
			end
			S_PBW: begin
				ctl.res_ld = 1'b1;
				ctl.ptr_op = ose_pkg::PT_ZERO;
				if (sts.single) begin
					ctl.cnt_op = ose_pkg::CN_DEC;
					state_d    = S_FIN;
				end else begin
					state_d = S_SHR;
				end
			end
			S_PRA: begin
				ctl.rd_en  = 1'b1;
				ctl.rd_sel = ose_pkg::RA_I;
				state_d    = S_PRB;
			end
			S_PRB: begin
				ctl.rd_en  = 1'b1;
				ctl.rd_sel = ose_pkg::RA_K;
				ctl.tmp_ld = 1'b1;
				state_d    = S_PWA;
			end
			S_PWA: begin
				ctl.wr_en  = 1'b1;
				ctl.wr_sel = ose_pkg::WA_I;
				ctl.wd_sel = ose_pkg::WD_RD;
				state_d    = S_PWB;
			end
			S_PWB: begin
				ctl.wr_en  = 1'b1;
				ctl.wr_sel = ose_pkg::WA_K;
				ctl.wd_sel = ose_pkg::WD_TMP;
				ctl.ptr_op = ose_pkg::PT_STEP;
				if ((sts.cmd == ose_pkg::CMD_REV) && sts.rev_more) begin
					state_d = S_PRA;
				end else begin
					state_d = S_FIN;
				end
			end
			S_MVRD: begin
				ctl.rd_en  = 1'b1;
				ctl.rd_sel = ose_pkg::RA_IDX;
				ctl.ptr_op = ose_pkg::PT_IDX;
				state_d    = S_MVT;
			end
			S_MVT: begin
				ctl.tmp_ld = 1'b1;
				state_d    = S_SHR;
			end
			S_SHR: begin
				ctl.rd_en  = 1'b1;
				ctl.rd_sel = ose_pkg::RA_K1;
				state_d    = S_SHW;
			end
			S_SHW: begin
				ctl.wr_en  = 1'b1;
				ctl.wr_sel = ose_pkg::WA_K;
				ctl.wd_sel = ose_pkg::WD_RD;
				ctl.ptr_op = ose_pkg::PT_KINC;
				if (sts.sh_more) begin
					state_d = S_SHR;
				end else if (sts.cmd == ose_pkg::CMD_POPB) begin
					ctl.cnt_op = ose_pkg::CN_DEC;
					state_d    = S_FIN;
				end else begin
					state_d = S_MVEND;
				end
			end
			S_MVEND: begin
				ctl.wr_en  = 1'b1;
				ctl.wr_sel = ose_pkg::WA_TOP;
				ctl.wd_sel = ose_pkg::WD_TMP;
				ctl.rep_op = ose_pkg::RP_DEC;
				state_d    = sts.rep_gt1 ? S_MVRD : S_FIN;
			end
			S_FIN: begin
				if (slot_free) begin
					state_d = s_tvalid ? S_DEC : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_ld) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire
